// ===== sv/pmpt_pkg.sv =====
// ============================================================================
// pmpt_pkg
// Types, constants and helpers shared by the mouse position tracker.
// ============================================================================
package pmpt_pkg;

    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 16;
    localparam int BTN_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int DELTA_W   = 9;
    localparam int SUM_W     = COORD_W + 2;

    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    typedef logic [1:0] byte_idx_t;

    localparam byte_idx_t IDX_HEADER = 2'd0;
    localparam byte_idx_t IDX_DX     = 2'd1;
    localparam byte_idx_t IDX_DY     = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X,
        CFG_MIN_Y,
        CFG_MAX_X,
        CFG_MAX_Y
    } cfg_idx_t;

    localparam logic signed [COORD_W-1:0] MIN_X_RESET = 16'sd0;
    localparam logic signed [COORD_W-1:0] MIN_Y_RESET = 16'sd0;
    localparam logic signed [COORD_W-1:0] MAX_X_RESET = 16'sd319;
    localparam logic signed [COORD_W-1:0] MAX_Y_RESET = 16'sd199;

    typedef struct packed {
        logic              complete;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] dx_low;
        logic [BYTE_W-1:0] dy_low;
    } pkt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cursor_x;
        logic signed [COORD_W-1:0] cursor_y;
        logic [BTN_W-1:0]          buttons;
        logic                      dropped;
    } res_t;

    function automatic logic signed [DELTA_W-1:0] delta9(
        input logic [BYTE_W-1:0] low,
        input logic              neg
    );
        return $signed({neg, low});
    endfunction

    // lower bound first, upper bound second
    function automatic logic signed [COORD_W-1:0] clamp(
        input logic signed [SUM_W-1:0]   v,
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] lo_w;
        logic signed [SUM_W-1:0] hi_w;
        r    = v;
        lo_w = SUM_W'(lo);
        hi_w = SUM_W'(hi);
        if (r < lo_w)
        begin
            r = lo_w;
        end
        if (r > hi_w)
        begin
            r = hi_w;
        end
        return r[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/pmpt_if.sv =====
// ============================================================================
// pmpt_if
// Valid/ready channels for controller bytes and cursor results.
// ============================================================================
interface pmpt_in_if;
    logic                         valid;
    logic                         ready;
    logic [pmpt_pkg::BYTE_W-1:0]  rx_byte;
    logic                         from_aux;

    modport source (output valid, output rx_byte, output from_aux, input ready);
    modport sink   (input valid, input rx_byte, input from_aux, output ready);
endinterface

interface pmpt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pmpt_pkg::COORD_W-1:0] cursor_x;
    logic signed [pmpt_pkg::COORD_W-1:0] cursor_y;
    logic [pmpt_pkg::BTN_W-1:0]          buttons;
    logic                                dropped;

    modport source (output valid, output cursor_x, output cursor_y, output buttons,
                    output dropped, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                    input dropped, output ready);
endinterface

// ===== sv/pmpt_assembler.sv =====
// ============================================================================
// pmpt_assembler
// Gathers mouse port bytes into three-byte packets.
// ============================================================================
module pmpt_assembler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [pmpt_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        from_aux,
    output pmpt_pkg::pkt_t              pkt
);
    import pmpt_pkg::*;

    byte_idx_t         idx_reg;
    byte_idx_t         idx_next;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] dx_reg;
    logic              take;

    assign take = fire && from_aux;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            case (idx_reg)
                IDX_HEADER: idx_next = IDX_DX;
                IDX_DX:     idx_next = IDX_DY;
                default:    idx_next = IDX_HEADER;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_HEADER;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && idx_reg == IDX_HEADER)
        begin
            header_reg <= rx_byte;
        end
        if (take && idx_reg == IDX_DX)
        begin
            dx_reg <= rx_byte;
        end
    end

    always_comb
    begin
        pkt.complete = take && (idx_reg >= IDX_DY);
        pkt.header   = header_reg;
        pkt.dx_low   = dx_reg;
        pkt.dy_low   = rx_byte;
    end

endmodule

// ===== sv/pmpt_tracker.sv =====
// ============================================================================
// pmpt_tracker
// Bound registers, cursor accumulate and clamp, button state.
// ============================================================================
module pmpt_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pmpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmpt_pkg::COORD_W-1:0]   cfg_data,
    input  pmpt_pkg::pkt_t                 pkt,
    output pmpt_pkg::res_t                 res
);
    import pmpt_pkg::*;

    logic signed [COORD_W-1:0] min_x_reg;
    logic signed [COORD_W-1:0] min_y_reg;
    logic signed [COORD_W-1:0] max_x_reg;
    logic signed [COORD_W-1:0] max_y_reg;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    logic signed [COORD_W-1:0] pos_x_next;
    logic signed [COORD_W-1:0] pos_y_next;
    logic [BTN_W-1:0]          btn_reg;
    logic [BTN_W-1:0]          btn_next;
    logic                      drop;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= MIN_X_RESET;
            min_y_reg <= MIN_Y_RESET;
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_X: min_x_reg <= $signed(cfg_data);
                CFG_MIN_Y: min_y_reg <= $signed(cfg_data);
                CFG_MAX_X: max_x_reg <= $signed(cfg_data);
                CFG_MAX_Y: max_y_reg <= $signed(cfg_data);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        drop  = pkt.header[XOVF_BIT] || pkt.header[YOVF_BIT];
        dx    = delta9(pkt.dx_low, pkt.header[XSIGN_BIT]);
        dy    = delta9(pkt.dy_low, pkt.header[YSIGN_BIT]);
        sum_x = SUM_W'(pos_x_reg) + SUM_W'(dx);
        sum_y = SUM_W'(pos_y_reg) - SUM_W'(dy);

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        btn_next   = btn_reg;
        if (pkt.complete && !drop)
        begin
            pos_x_next = clamp(sum_x, min_x_reg, max_x_reg);
            pos_y_next = clamp(sum_y, min_y_reg, max_y_reg);
            btn_next   = pkt.header[BTN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            btn_reg   <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            btn_reg   <= btn_next;
        end
    end

    always_comb
    begin
        res.cursor_x = pos_x_next;
        res.cursor_y = pos_y_next;
        res.buttons  = btn_next;
        res.dropped  = drop;
    end

endmodule

// ===== sv/ps2_mouse_position_tracker_core.sv =====
// ============================================================================
// ps2_mouse_position_tracker_core
// PS/2 mouse packet decoder with a clamped cursor position.
// ============================================================================
// Result valid in the cycle after the transfer of a packet's third byte.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Timing is set by the single accumulate-and-clamp path into the result register.
// Reset: byte position, cursor and buttons clear; bounds return to 0..319, 0..199.
module ps2_mouse_position_tracker_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pmpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmpt_pkg::COORD_W-1:0]   cfg_data,
    pmpt_in_if.sink                        in_ch,
    pmpt_out_if.source                     out_ch
);
    import pmpt_pkg::*;

    pkt_t pkt;
    res_t res;
    res_t res_reg;
    logic fire;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign fire        = in_ch.valid && in_ch.ready;

    pmpt_assembler u_assembler (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .rx_byte  (in_ch.rx_byte),
        .from_aux (in_ch.from_aux),
        .pkt      (pkt)
    );

    pmpt_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pkt       (pkt),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pkt.complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.complete)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.cursor_x = res_reg.cursor_x;
    assign out_ch.cursor_y = res_reg.cursor_y;
    assign out_ch.buttons  = res_reg.buttons;
    assign out_ch.dropped  = res_reg.dropped;

endmodule

// ===== sv/pmpt_checker.sv =====
// ============================================================================
// pmpt_checker
// Port-level checks of the mouse position tracker, bound to the top level.
// ============================================================================
module pmpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_from_aux,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_cursor_x,
    input logic [15:0] out_cursor_y,
    input logic [2:0]  out_buttons,
    input logic        out_dropped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_cursor_x, out_cursor_y,
                                             out_buttons, out_dropped}))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_no_result_from_host_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_from_aux |=> !out_valid)
        else $error("result raised by a non-mouse byte");

endmodule

bind ps2_mouse_position_tracker_core pmpt_checker u_pmpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_from_aux  (in_ch.from_aux),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_cursor_x (out_ch.cursor_x),
    .out_cursor_y (out_ch.cursor_y),
    .out_buttons  (out_ch.buttons),
    .out_dropped  (out_ch.dropped)
);
